/* hdl/pbmup_pkg.sv */
// ----------------------------------------------------------------------------
// pbmup_pkg
// shared types, codes and command tables for the pbm upscale block
// ----------------------------------------------------------------------------
package pbmup_pkg;

	localparam int MAX_IN_WIDTH  = 256;
	localparam int MAX_IN_HEIGHT = 49151;
	localparam int LINE_BYTES    = 43;
	localparam int LBUF_AW       = $clog2(LINE_BYTES);

	// ascii codes
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_4     = 8'h34;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;

	localparam int HDR_LEN  = 13;
	localparam int TAIL_LEN = 7;

	typedef enum logic [1:0] {
		ERR_NONE   = 2'd0,
		ERR_SYNTAX = 2'd1,
		ERR_SIZE   = 2'd2,
		ERR_TRUNC  = 2'd3
	} err_t;

	typedef enum logic [3:0] {
		PH_MAGIC1, PH_MAGIC2, PH_WS1, PH_WIDTH, PH_WS2, PH_HEIGHT,
		PH_DATA, PH_DONE, PH_ERROR
	} phase_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CALC, ST_CHECK, ST_HDR, ST_BIT, ST_FLUSH,
		ST_RD, ST_RDW, ST_TAIL, ST_LASTCHK, ST_FIN
	} state_t;

	typedef struct packed {
		logic [7:0] file_byte;
		logic       first_of_file;
		logic       last_of_file;
	} pbm_t;

	typedef struct packed {
		logic [7:0] out_byte;
		err_t       error_code;
		logic       end_of_job;
		logic       last_of_run;
	} prn_t;

	function automatic logic is_ws(input logic [7:0] b);
		return b == CH_SPACE || b == CH_LF || b == CH_CR || b == CH_TAB;
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b >= CH_ZERO && b <= CH_NINE;
	endfunction

	// init, center, raster command and its size words
	function automatic logic [7:0] hdr_byte(input logic [5:0] idx, input logic [7:0] sbpr,
		input logic [15:0] sh);
		logic [7:0] r;
		unique case (idx)
			6'd0:    r = 8'h1B;
			6'd1:    r = 8'h40;
			6'd2:    r = 8'h1B;
			6'd3:    r = 8'h61;
			6'd4:    r = 8'h01;
			6'd5:    r = 8'h1D;
			6'd6:    r = 8'h76;
			6'd7:    r = 8'h30;
			6'd8:    r = 8'h00;
			6'd9:    r = sbpr;
			6'd10:   r = 8'h00;
			6'd11:   r = sh[7:0];
			6'd12:   r = sh[15:8];
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// feed three lines, then cut
	function automatic logic [7:0] tail_byte(input logic [5:0] idx);
		logic [7:0] r;
		unique case (idx)
			6'd0:    r = 8'h1B;
			6'd1:    r = 8'h64;
			6'd2:    r = 8'h03;
			6'd3:    r = 8'h1D;
			6'd4:    r = 8'h56;
			6'd5:    r = 8'h41;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

/* hdl/pbm_upscale_to_printer_raster.sv */
// ----------------------------------------------------------------------------
// pbm_upscale_to_printer_raster
// parses a binary pbm file and streams a 4/3 upscaled printer raster job
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-------------------------------
//  pbm     | in  | pbm_valid/pbm_stall  | pbm_req   (one file byte)
//  prn     | out | prn_valid/prn_stall  | prn_data  (one printer byte)
//
//  a request: taken in idle, its work, then a last check and a finish state;
//  a header end adds size math and thirteen command bytes, a raster byte packs
//  its output bits one by one, a row end adds a flush, a replay reads each
//  byte from the line buffer, and a tail sends seven bytes
//  reset clears all control state; the line buffer is not cleared
//  prn_stall holds the sequencer once output and hold are full; pbm_stall: busy
//
module pbm_upscale_to_printer_raster (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pbm_valid,
	output logic               pbm_stall,
	input  pbmup_pkg::pbm_t    pbm_req,
	output logic               prn_valid,
	input  logic               prn_stall,
	output pbmup_pkg::prn_t    prn_data
);

	// sequencer and parse state
	pbmup_pkg::state_t state_q, state_d;
	pbmup_pkg::phase_t phase_q;

	// header values
	logic [15:0] acc_q;
	logic [8:0]  w_q;
	logic [15:0] h_q;
	logic [7:0]  sbpr_q;
	logic [15:0] sh_q;

	// raster position
	logic [5:0]  col_q;
	logic [15:0] rc_q;
	logic [1:0]  rowph_q;
	logic [1:0]  pix_q;
	logic        dup_q;
	logic [7:0]  pend_q;
	logic [2:0]  pcnt_q;
	logic [5:0]  ocol_q;
	logic        row_done_q;

	// current request
	logic [7:0]  byte_q;
	logic        last_q;
	logic [3:0]  nb_q;
	logic [5:0]  cnt_q;

	// hold stage and output register
	pbmup_pkg::prn_t hold_q, prn_q;
	logic            hold_v_q, prn_v_q;

	// line buffer
	logic [7:0]                    lbuf_mem [pbmup_pkg::LINE_BYTES];
	logic [7:0]                    rd_q;
	logic                          mem_we, rd_en;
	logic [pbmup_pkg::LBUF_AW-1:0] mem_wa;

	// combinational helpers
	logic              accept, out_free, ok;
	logic              push_en;
	pbmup_pkg::prn_t   push_res;
	pbmup_pkg::phase_t eff_phase;
	logic [15:0]       eff_acc;
	logic              pfail, b_ws, b_dig;
	logic [7:0]        b;
	logic [19:0]       acc_mul;
	logic [15:0]       acc_sat;
	logic [20:0]       w_prod;
	logic [9:0]        w_q3;
	logic [7:0]        sbpr_d;
	logic [35:0]       h_prod;
	logic              size_bad;
	logic              cur_bit;
	logic [7:0]        newbits;
	logic [8:0]        rem;
	logic [5:0]        in_bpr;
	logic              row_done_d;
	logic              need_trunc;
	logic              wr_ok;

	assign b        = pbm_req.file_byte;
	assign accept   = (state_q == pbmup_pkg::ST_IDLE) && pbm_valid;
	assign out_free = !prn_v_q || !prn_stall;
	assign ok       = !hold_v_q || out_free;

	assign eff_phase = pbm_req.first_of_file ? pbmup_pkg::PH_MAGIC1 : phase_q;
	assign eff_acc   = pbm_req.first_of_file ? 16'd0 : acc_q;
	assign b_ws      = pbmup_pkg::is_ws(b);
	assign b_dig     = pbmup_pkg::is_digit(b);

	// decimal accumulate, saturating at 16 bits
	assign acc_mul = eff_acc * 20'd10 + {12'd0, b - pbmup_pkg::CH_ZERO};
	assign acc_sat = (acc_mul > 20'd65535) ? 16'hFFFF : acc_mul[15:0];

	always_comb begin
		unique case (eff_phase)
			pbmup_pkg::PH_MAGIC1: pfail = (b != pbmup_pkg::CH_P);
			pbmup_pkg::PH_MAGIC2: pfail = (b != pbmup_pkg::CH_4);
			pbmup_pkg::PH_WS1, pbmup_pkg::PH_WS2,
			pbmup_pkg::PH_WIDTH, pbmup_pkg::PH_HEIGHT: pfail = !b_dig && !b_ws;
			default: pfail = 1'b0;
		endcase
	end

	// scaled sizes: x/3 as multiply by reciprocal, exact over the value range
	assign w_prod = {w_q, 2'b00} * 21'd683;
	assign w_q3   = w_prod[20:11];
	assign sbpr_d = 8'((w_q3 + 10'd7) >> 3);
	assign h_prod = {18'd0, h_q, 2'b00} * 36'd174763;

	assign size_bad = (w_q == 9'd0) || (w_q > 9'(pbmup_pkg::MAX_IN_WIDTH)) || (h_q == 16'd0)
		|| (h_q > 16'(pbmup_pkg::MAX_IN_HEIGHT)) || (sbpr_q > 8'(pbmup_pkg::LINE_BYTES));

	// bit packing
	assign cur_bit = byte_q[3'd7 - cnt_q[2:0]];
	assign newbits = pend_q | (cur_bit ? (8'h80 >> pcnt_q) : 8'h00);
	assign rem     = w_q - {col_q[5:0], 3'b000};
	assign in_bpr  = 6'((w_q + 9'd7) >> 3);
	assign row_done_d = (rc_q + 16'd1) >= h_q;
	assign need_trunc = last_q && phase_q != pbmup_pkg::PH_DONE
		&& phase_q != pbmup_pkg::PH_ERROR;
	assign wr_ok = (rowph_q == 2'd2) && (ocol_q < 6'(pbmup_pkg::LINE_BYTES));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pbmup_pkg::ST_IDLE: begin
				if (pbm_valid) begin
					if (pfail)
						state_d = pbmup_pkg::ST_FIN;
					else if (eff_phase == pbmup_pkg::PH_HEIGHT && b_ws)
						state_d = pbmup_pkg::ST_CALC;
					else if (eff_phase == pbmup_pkg::PH_DATA)
						state_d = pbmup_pkg::ST_BIT;
					else
						state_d = pbmup_pkg::ST_LASTCHK;
				end
			end
			pbmup_pkg::ST_CALC: state_d = pbmup_pkg::ST_CHECK;
			pbmup_pkg::ST_CHECK: begin
				if (!size_bad)
					state_d = pbmup_pkg::ST_HDR;
				else if (ok)
					state_d = pbmup_pkg::ST_FIN;
			end
			pbmup_pkg::ST_HDR: begin
				if (ok && cnt_q == 6'(pbmup_pkg::HDR_LEN - 1))
					state_d = pbmup_pkg::ST_LASTCHK;
			end
			pbmup_pkg::ST_BIT: begin
				if (cnt_q == {2'd0, nb_q})
					state_d = (col_q + 6'd1 < in_bpr) ? pbmup_pkg::ST_LASTCHK
						: pbmup_pkg::ST_FLUSH;
			end
			pbmup_pkg::ST_FLUSH: begin
				if (pcnt_q == 3'd0 || ok) begin
					if (rowph_q == 2'd2)
						state_d = pbmup_pkg::ST_RD;
					else if (row_done_d)
						state_d = pbmup_pkg::ST_TAIL;
					else
						state_d = pbmup_pkg::ST_LASTCHK;
				end
			end
			pbmup_pkg::ST_RD: begin
				if ({2'd0, cnt_q} < sbpr_q)
					state_d = pbmup_pkg::ST_RDW;
				else
					state_d = row_done_q ? pbmup_pkg::ST_TAIL : pbmup_pkg::ST_LASTCHK;
			end
			pbmup_pkg::ST_RDW: if (ok) state_d = pbmup_pkg::ST_RD;
			pbmup_pkg::ST_TAIL: begin
				if (ok && cnt_q == 6'(pbmup_pkg::TAIL_LEN - 1))
					state_d = pbmup_pkg::ST_LASTCHK;
			end
			pbmup_pkg::ST_LASTCHK: if (!need_trunc || ok) state_d = pbmup_pkg::ST_FIN;
			pbmup_pkg::ST_FIN: if (!hold_v_q || out_free) state_d = pbmup_pkg::ST_IDLE;
			default: state_d = pbmup_pkg::ST_IDLE;
		endcase
	end

	// result and line buffer controls
	always_comb begin
		push_en  = 1'b0;
		push_res = '{out_byte: 8'h00, error_code: pbmup_pkg::ERR_NONE, end_of_job: 1'b0,
			last_of_run: 1'b0};
		mem_we   = 1'b0;
		rd_en    = 1'b0;
		unique case (state_q)
			pbmup_pkg::ST_IDLE: begin
				push_en = accept && pfail;
				push_res.error_code = pbmup_pkg::ERR_SYNTAX;
				push_res.end_of_job = 1'b1;
			end
			pbmup_pkg::ST_CHECK: begin
				push_en = size_bad;
				push_res.error_code = pbmup_pkg::ERR_SIZE;
				push_res.end_of_job = 1'b1;
			end
			pbmup_pkg::ST_HDR: begin
				push_en = 1'b1;
				push_res.out_byte = pbmup_pkg::hdr_byte(cnt_q, sbpr_q, sh_q);
			end
			pbmup_pkg::ST_BIT: begin
				push_en = (cnt_q != {2'd0, nb_q}) && pcnt_q == 3'd7;
				push_res.out_byte = newbits;
				mem_we = push_en && ok && wr_ok;
			end
			pbmup_pkg::ST_FLUSH: begin
				push_en = pcnt_q != 3'd0;
				push_res.out_byte = pend_q;
				mem_we = push_en && ok && wr_ok;
			end
			pbmup_pkg::ST_RD: rd_en = {2'd0, cnt_q} < sbpr_q;
			pbmup_pkg::ST_RDW: begin
				push_en = 1'b1;
				push_res.out_byte = rd_q;
			end
			pbmup_pkg::ST_TAIL: begin
				push_en = 1'b1;
				push_res.out_byte = pbmup_pkg::tail_byte(cnt_q);
				push_res.end_of_job = cnt_q == 6'(pbmup_pkg::TAIL_LEN - 1);
			end
			pbmup_pkg::ST_LASTCHK: begin
				push_en = need_trunc;
				push_res.error_code = pbmup_pkg::ERR_TRUNC;
				push_res.end_of_job = 1'b1;
			end
			default: ;
		endcase
	end

	assign mem_wa = ocol_q[pbmup_pkg::LBUF_AW-1:0];

	// line buffer, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we)
			lbuf_mem[mem_wa] <= newbits & {8{state_q == pbmup_pkg::ST_BIT}}
				| pend_q & {8{state_q == pbmup_pkg::ST_FLUSH}};
		if (rd_en)
			rd_q <= lbuf_mem[cnt_q[pbmup_pkg::LBUF_AW-1:0]];
	end

	// result path: the newest result waits in hold until the next or the run end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			prn_v_q  <= 1'b0;
		end else begin
			if (push_en && ok) begin
				hold_v_q <= 1'b1;
				if (hold_v_q) prn_v_q <= 1'b1;
				else if (out_free) prn_v_q <= 1'b0;
			end else if (state_q == pbmup_pkg::ST_FIN && hold_v_q && out_free) begin
				hold_v_q <= 1'b0;
				prn_v_q  <= 1'b1;
			end else if (out_free) begin
				prn_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_en && ok) begin
			hold_q <= push_res;
			if (hold_v_q) prn_q <= hold_q;
		end else if (state_q == pbmup_pkg::ST_FIN && hold_v_q && out_free) begin
			prn_q <= '{out_byte: hold_q.out_byte, error_code: hold_q.error_code,
				end_of_job: hold_q.end_of_job, last_of_run: 1'b1};
		end
	end

	// sequencer and job state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= pbmup_pkg::ST_IDLE;
			phase_q    <= pbmup_pkg::PH_MAGIC1;
			acc_q      <= '0;
			w_q        <= '0;
			h_q        <= '0;
			sbpr_q     <= '0;
			sh_q       <= '0;
			col_q      <= '0;
			rc_q       <= '0;
			rowph_q    <= '0;
			pix_q      <= '0;
			dup_q      <= 1'b0;
			pend_q     <= '0;
			pcnt_q     <= '0;
			ocol_q     <= '0;
			row_done_q <= 1'b0;
			byte_q     <= '0;
			last_q     <= 1'b0;
			nb_q       <= '0;
			cnt_q      <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				pbmup_pkg::ST_IDLE: begin
					if (pbm_valid) begin
						byte_q <= b;
						last_q <= pbm_req.last_of_file;
						cnt_q  <= '0;
						nb_q   <= (rem > 9'd8) ? 4'd8 : rem[3:0];
						// restart drops any job in progress, the phase follows below
						if (pbm_req.first_of_file) begin
							acc_q   <= '0;
							w_q     <= '0;
							h_q     <= '0;
							col_q   <= '0;
							rc_q    <= '0;
							rowph_q <= '0;
							pix_q   <= '0;
							dup_q   <= 1'b0;
							pend_q  <= '0;
							pcnt_q  <= '0;
							ocol_q  <= '0;
						end
						if (pfail) begin
							phase_q <= pbmup_pkg::PH_ERROR;
						end else begin
							unique case (eff_phase)
								pbmup_pkg::PH_MAGIC1: phase_q <= pbmup_pkg::PH_MAGIC2;
								pbmup_pkg::PH_MAGIC2: phase_q <= pbmup_pkg::PH_WS1;
								pbmup_pkg::PH_WS1, pbmup_pkg::PH_WS2: begin
									if (b_dig) begin
										acc_q   <= {8'd0, b - pbmup_pkg::CH_ZERO};
										phase_q <= (eff_phase == pbmup_pkg::PH_WS1)
											? pbmup_pkg::PH_WIDTH : pbmup_pkg::PH_HEIGHT;
									end
								end
								pbmup_pkg::PH_WIDTH: begin
									if (b_dig) begin
										acc_q <= acc_sat;
									end else begin
										w_q     <= (eff_acc > 16'd511) ? 9'd511 : eff_acc[8:0];
										acc_q   <= '0;
										phase_q <= pbmup_pkg::PH_WS2;
									end
								end
								pbmup_pkg::PH_HEIGHT: begin
									if (b_dig) begin
										acc_q <= acc_sat;
									end else begin
										h_q   <= eff_acc;
										acc_q <= '0;
									end
								end
								default: ;
							endcase
						end
					end
				end
				pbmup_pkg::ST_CALC: begin
					sbpr_q <= sbpr_d;
					sh_q   <= h_prod[34:19];
				end
				pbmup_pkg::ST_CHECK: begin
					if (size_bad) begin
						if (ok) phase_q <= pbmup_pkg::PH_ERROR;
					end else begin
						phase_q <= pbmup_pkg::PH_DATA;
						cnt_q   <= '0;
						col_q   <= '0;
						rc_q    <= '0;
						rowph_q <= '0;
						pix_q   <= '0;
						dup_q   <= 1'b0;
						pend_q  <= '0;
						pcnt_q  <= '0;
						ocol_q  <= '0;
					end
				end
				pbmup_pkg::ST_HDR: if (ok) cnt_q <= cnt_q + 6'd1;
				pbmup_pkg::ST_BIT: begin
					if (cnt_q == {2'd0, nb_q}) begin
						col_q <= col_q + 6'd1;
						cnt_q <= '0;
					end else if (pcnt_q != 3'd7 || ok) begin
						if (pcnt_q == 3'd7) begin
							pend_q <= '0;
							pcnt_q <= '0;
							if (ocol_q != 6'd63) ocol_q <= ocol_q + 6'd1;
						end else begin
							pend_q <= newbits;
							pcnt_q <= pcnt_q + 3'd1;
						end
						// every third pixel goes out twice
						if (dup_q) begin
							dup_q <= 1'b0;
							pix_q <= '0;
							cnt_q <= cnt_q + 6'd1;
						end else if (pix_q == 2'd2) begin
							dup_q <= 1'b1;
						end else begin
							pix_q <= pix_q + 2'd1;
							cnt_q <= cnt_q + 6'd1;
						end
					end
				end
				pbmup_pkg::ST_FLUSH: begin
					if (pcnt_q == 3'd0 || ok) begin
						pend_q     <= '0;
						pcnt_q     <= '0;
						pix_q      <= '0;
						col_q      <= '0;
						ocol_q     <= '0;
						cnt_q      <= '0;
						rowph_q    <= (rowph_q == 2'd2) ? 2'd0 : rowph_q + 2'd1;
						rc_q       <= rc_q + 16'd1;
						row_done_q <= row_done_d;
					end
				end
				pbmup_pkg::ST_RD: if ({2'd0, cnt_q} >= sbpr_q) cnt_q <= '0;
				pbmup_pkg::ST_RDW: if (ok) cnt_q <= cnt_q + 6'd1;
				pbmup_pkg::ST_TAIL: begin
					if (ok) begin
						cnt_q <= cnt_q + 6'd1;
						if (cnt_q == 6'(pbmup_pkg::TAIL_LEN - 1)) phase_q <= pbmup_pkg::PH_DONE;
					end
				end
				pbmup_pkg::ST_LASTCHK: if (need_trunc && ok) phase_q <= pbmup_pkg::PH_ERROR;
				default: ;
			endcase
		end
	end

	assign pbm_stall = state_q != pbmup_pkg::ST_IDLE;
	assign prn_valid = prn_v_q;
	assign prn_data  = prn_q;

`ifndef SYNTHESIS
	a_idle_hold_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!pbm_stall |-> !hold_v_q) else $error("request taken with result in hold");
	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> ocol_q < 6'(pbmup_pkg::LINE_BYTES)) else $error("line write out of range");
	a_rd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> cnt_q < 6'(pbmup_pkg::LINE_BYTES)) else $error("line read out of range");
	a_err_ends_job: assert property (@(posedge clk) disable iff (!arst_n)
		prn_valid && prn_data.error_code != pbmup_pkg::ERR_NONE |-> prn_data.end_of_job)
		else $error("error result without end of job");
`endif

endmodule

/* test/pbm_upscale_to_printer_raster_test.sv */
// ----------------------------------------------------------------------------
// pbm_upscale_to_printer_raster_test
// feeds pbm files byte by byte, predicts the printer byte stream per request
// and checks every printer byte in order against that prediction
// ----------------------------------------------------------------------------
module pbm_upscale_to_printer_raster_test;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pbm_valid = 1'b0;
	logic pbm_stall;
	pbmup_pkg::pbm_t pbm_req = '0;
	logic prn_valid;
	logic prn_stall = 1'b0;
	pbmup_pkg::prn_t prn_data;

	pbm_upscale_to_printer_raster i_dut (
		.clk(clk), .arst_n(arst_n),
		.pbm_valid(pbm_valid), .pbm_stall(pbm_stall), .pbm_req(pbm_req),
		.prn_valid(prn_valid), .prn_stall(prn_stall), .prn_data(prn_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// predictor state, one copy of the parser and raster packer
	// ------------------------------------------------------------------
	pbmup_pkg::phase_t pr_phase;
	int unsigned pr_width, pr_height, pr_acc, pr_in_col, pr_rows, pr_row_ph;
	int unsigned pr_pix_ph, pr_bits, pr_nbits, pr_out_col;
	logic [7:0] pr_line [pbmup_pkg::LINE_BYTES];

	pbmup_pkg::pbm_t pending_bytes[$];     // requests waiting for the driver
	pbmup_pkg::prn_t printer_bytes[$];     // expected printer bytes, oldest first
	int   n_fail = 0;
	int   n_items = 0;          // requests queued so far
	bit   quiet = 0;            // last stretch: no idling
	bit   hold_off = 0;         // sender pauses while set

	function automatic int unsigned row_out_bytes();
		return ((pr_width * 4) / 3 + 7) / 8;
	endfunction

	function automatic void emit(logic [7:0] b, pbmup_pkg::err_t e, logic eoj);
		pbmup_pkg::prn_t r;
		r.out_byte = b;
		r.error_code = e;
		r.end_of_job = eoj;
		r.last_of_run = 1'b0;
		printer_bytes.push_back(r);
	endfunction

	function automatic void raise(pbmup_pkg::err_t e);
		emit(8'h00, e, 1'b1);
		pr_phase = pbmup_pkg::PH_ERROR;
	endfunction

	function automatic void raster_byte(logic [7:0] b);
		if (pr_row_ph == 2 && pr_out_col < pbmup_pkg::LINE_BYTES) pr_line[pr_out_col] = b;
		if (pr_out_col < 63) pr_out_col++;
		emit(b, pbmup_pkg::ERR_NONE, 1'b0);
	endfunction

	function automatic void pack_bit(logic bitv);
		if (bitv) pr_bits |= 8'h80 >> (pr_nbits & 7);
		pr_nbits++;
		if (pr_nbits >= 8) begin
			raster_byte(pr_bits[7:0]);
			pr_bits = 0;
			pr_nbits = 0;
		end
	endfunction

	function automatic void clear_job();
		pr_width = 0; pr_height = 0; pr_acc = 0; pr_in_col = 0; pr_rows = 0;
		pr_row_ph = 0; pr_pix_ph = 0; pr_bits = 0; pr_nbits = 0; pr_out_col = 0;
	endfunction

	function automatic bit ws(logic [7:0] b);
		return b == 8'h20 || b == 8'h0A || b == 8'h0D || b == 8'h09;
	endfunction

	function automatic bit dig(logic [7:0] b);
		return b >= 8'h30 && b <= 8'h39;
	endfunction

	function automatic void add_digit(logic [7:0] b);
		int unsigned v;
		v = pr_acc * 10 + (b - 8'h30);
		pr_acc = v > 65535 ? 65535 : v;
	endfunction

	// one file byte in, its printer bytes appended to printer_bytes
	function automatic void convert_byte(pbmup_pkg::pbm_t q);
		int unsigned base, in_bpr, used, nb, sbpr, sh, i;
		logic bitv;
		logic [7:0] b;
		b = q.file_byte;
		base = printer_bytes.size();
		if (q.first_of_file) begin
			clear_job();
			pr_phase = pbmup_pkg::PH_MAGIC1;
		end
		case (pr_phase)
			pbmup_pkg::PH_MAGIC1: begin
				if (b == pbmup_pkg::CH_P) pr_phase = pbmup_pkg::PH_MAGIC2;
				else raise(pbmup_pkg::ERR_SYNTAX);
			end
			pbmup_pkg::PH_MAGIC2: begin
				if (b == pbmup_pkg::CH_4) pr_phase = pbmup_pkg::PH_WS1;
				else raise(pbmup_pkg::ERR_SYNTAX);
			end
			pbmup_pkg::PH_WS1, pbmup_pkg::PH_WS2: begin
				if (dig(b)) begin
					pr_acc = b - 8'h30;
					pr_phase = (pr_phase == pbmup_pkg::PH_WS1) ? pbmup_pkg::PH_WIDTH
						: pbmup_pkg::PH_HEIGHT;
				end else if (!ws(b)) raise(pbmup_pkg::ERR_SYNTAX);
			end
			pbmup_pkg::PH_WIDTH: begin
				if (dig(b)) add_digit(b);
				else if (ws(b)) begin
					pr_width = pr_acc > 511 ? 511 : pr_acc;
					pr_acc = 0;
					pr_phase = pbmup_pkg::PH_WS2;
				end else raise(pbmup_pkg::ERR_SYNTAX);
			end
			pbmup_pkg::PH_HEIGHT: begin
				if (dig(b)) add_digit(b);
				else if (ws(b)) begin
					pr_height = pr_acc & 16'hFFFF;
					pr_acc = 0;
					if (pr_width == 0 || pr_width > pbmup_pkg::MAX_IN_WIDTH || pr_height == 0 ||
						pr_height > pbmup_pkg::MAX_IN_HEIGHT ||
						row_out_bytes() > pbmup_pkg::LINE_BYTES)
						raise(pbmup_pkg::ERR_SIZE);
					else begin
						sbpr = row_out_bytes();
						sh = (pr_height * 4) / 3;
						emit(8'h1B, pbmup_pkg::ERR_NONE, 0); emit(8'h40, pbmup_pkg::ERR_NONE, 0);
						emit(8'h1B, pbmup_pkg::ERR_NONE, 0); emit(8'h61, pbmup_pkg::ERR_NONE, 0);
						emit(8'h01, pbmup_pkg::ERR_NONE, 0); emit(8'h1D, pbmup_pkg::ERR_NONE, 0);
						emit(8'h76, pbmup_pkg::ERR_NONE, 0); emit(8'h30, pbmup_pkg::ERR_NONE, 0);
						emit(8'h00, pbmup_pkg::ERR_NONE, 0);
						emit(sbpr[7:0], pbmup_pkg::ERR_NONE, 0);
						emit(sbpr[15:8], pbmup_pkg::ERR_NONE, 0);
						emit(sh[7:0], pbmup_pkg::ERR_NONE, 0);
						emit(sh[15:8], pbmup_pkg::ERR_NONE, 0);
						pr_in_col = 0; pr_rows = 0; pr_row_ph = 0; pr_pix_ph = 0;
						pr_bits = 0; pr_nbits = 0; pr_out_col = 0;
						pr_phase = pbmup_pkg::PH_DATA;
					end
				end else raise(pbmup_pkg::ERR_SYNTAX);
			end
			pbmup_pkg::PH_DATA: begin
				in_bpr = (pr_width + 7) / 8;
				used = pr_in_col * 8;
				nb = pr_width > used ? pr_width - used : 0;
				if (nb > 8) nb = 8;
				for (i = 0; i < nb; i++) begin
					bitv = b[7 - i];
					pack_bit(bitv);
					if (pr_pix_ph >= 2) begin
						pack_bit(bitv);
						pr_pix_ph = 0;
					end else pr_pix_ph++;
				end
				pr_in_col++;
				if (pr_in_col >= in_bpr) begin
					if (pr_nbits > 0) raster_byte(pr_bits[7:0]);
					pr_bits = 0; pr_nbits = 0; pr_pix_ph = 0; pr_in_col = 0;
					pr_out_col = 0;
					// every third row printed again from the line buffer
					if (pr_row_ph == 2) begin
						sbpr = row_out_bytes();
						for (i = 0; i < sbpr && i < pbmup_pkg::LINE_BYTES; i++)
							emit(pr_line[i], pbmup_pkg::ERR_NONE, 0);
						pr_row_ph = 0;
					end else pr_row_ph++;
					pr_rows = (pr_rows + 1) & 16'hFFFF;
					if (pr_rows >= pr_height) begin
						emit(8'h1B, pbmup_pkg::ERR_NONE, 0); emit(8'h64, pbmup_pkg::ERR_NONE, 0);
						emit(8'h03, pbmup_pkg::ERR_NONE, 0); emit(8'h1D, pbmup_pkg::ERR_NONE, 0);
						emit(8'h56, pbmup_pkg::ERR_NONE, 0); emit(8'h41, pbmup_pkg::ERR_NONE, 0);
						emit(8'h00, pbmup_pkg::ERR_NONE, 1);
						pr_phase = pbmup_pkg::PH_DONE;
					end
				end
			end
			default: ;
		endcase
		// file ended before the image was complete
		if (q.last_of_file && pr_phase != pbmup_pkg::PH_DONE &&
			pr_phase != pbmup_pkg::PH_ERROR)
			raise(pbmup_pkg::ERR_TRUNC);
		if (printer_bytes.size() > base)
			printer_bytes[printer_bytes.size() - 1].last_of_run = 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	task automatic put_byte(logic [7:0] b, bit first = 0, bit last = 0);
		pbmup_pkg::pbm_t q;
		q.file_byte = b;
		q.first_of_file = first;
		q.last_of_file = last;
		pending_bytes.push_back(q);
		n_items++;
	endtask

	task automatic put_text(string s, bit first = 0);
		for (int i = 0; i < s.len(); i++) put_byte(s[i], first && i == 0);
	endtask

	function automatic logic [7:0] any_ws();
		case ($urandom_range(0, 3))
			0: return 8'h20;
			1: return 8'h0A;
			2: return 8'h0D;
			default: return 8'h09;
		endcase
	endfunction

	// complete file; cut_at >= 0 truncates the pixel data after that many bytes
	task automatic put_file(int w, int h, int cut_at = -1);
		int nbytes;
		put_text("P4", 1);
		put_byte(any_ws());
		put_text($sformatf("%0d", w));
		repeat ($urandom_range(1, 2)) put_byte(any_ws());
		put_text($sformatf("%0d", h));
		nbytes = ((w + 7) / 8) * h;
		if (cut_at >= 0 && cut_at < nbytes) nbytes = cut_at;
		put_byte(any_ws(), 0, nbytes == 0);
		for (int i = 0; i < nbytes; i++) begin
			logic [7:0] v;
			case ($urandom_range(0, 3))
				0: v = 8'hFF;
				1: v = 8'h00;
				default: v = $urandom_range(0, 255);
			endcase
			put_byte(v, 0, i == nbytes - 1);
		end
	endtask

	// ------------------------------------------------------------------
	// driver: one request at a time, random idle bursts
	// ------------------------------------------------------------------
	int drv_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (pbm_valid && !pbm_stall) convert_byte(pbm_req);
			if (!pbm_valid || !pbm_stall) begin
				if (drv_gap > 0) begin
					drv_gap <= drv_gap - 1;
					pbm_valid <= 1'b0;
				end else if (pending_bytes.size() > 0 && !hold_off &&
					!(pbm_valid && !pbm_stall && pending_bytes.size() == 0)) begin
					if (!quiet && $urandom_range(0, 9) == 0) begin
						drv_gap <= $urandom_range(0, 5);
						pbm_valid <= 1'b0;
					end else begin
						pbm_req <= pending_bytes.pop_front();
						pbm_valid <= 1'b1;
					end
				end else pbm_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: checks every accepted printer byte, random stall bursts
	// ------------------------------------------------------------------
	int stall_left = 0;
	always @(posedge clk) begin
		pbmup_pkg::prn_t want;
		if (arst_n) begin
			if (prn_valid && !prn_stall) begin
				if (printer_bytes.size() == 0) begin
					$error("unexpected printer byte %h", prn_data.out_byte);
					n_fail++;
				end else begin
					want = printer_bytes.pop_front();
					if (prn_data.out_byte !== want.out_byte) begin
						$error("out_byte exp %h got %h", want.out_byte, prn_data.out_byte);
						n_fail++;
					end
					if (prn_data.error_code !== want.error_code) begin
						$error("error_code exp %0d got %0d", want.error_code,
							prn_data.error_code);
						n_fail++;
					end
					if (prn_data.end_of_job !== want.end_of_job) begin
						$error("end_of_job exp %b got %b", want.end_of_job,
							prn_data.end_of_job);
						n_fail++;
					end
					if (prn_data.last_of_run !== want.last_of_run) begin
						$error("last_of_run exp %b got %b", want.last_of_run,
							prn_data.last_of_run);
						n_fail++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				prn_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				stall_left <= $urandom_range(0, 5);
				prn_stall <= 1'b1;
			end else prn_stall <= 1'b0;
		end
	end

	task automatic drain();
		while (pending_bytes.size() > 0 || pbm_valid) @(posedge clk);
		while (printer_bytes.size() > 0) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------
	initial begin
		int w, h;
		clear_job();
		pr_phase = pbmup_pkg::PH_MAGIC1;
		for (int i = 0; i < pbmup_pkg::LINE_BYTES; i++) pr_line[i] = 8'h00;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: error paths, size extremes, replay rows, trailing bytes
		put_byte(8'h51);                      // bad magic right after reset
		put_byte(8'hAA);                      // ignored after error
		put_text("P5", 1);                    // bad second magic byte
		put_text("P4#", 1);                   // comment not supported
		put_text("P4 1x", 1);                 // junk inside a number
		put_text("P4 0 1 ", 1);               // width zero
		put_text("P4 257 1 ", 1);             // width too large
		put_text("P4 8 0 ", 1);               // height zero
		put_text("P4 8 99999 ", 1);           // saturating height
		put_text("P4 8 49152 ", 1);           // height just above limit
		put_text("P4\t1\r1\n", 1);            // 1x1 with tab, cr and lf, completed by its data byte
		put_byte(8'h80, 0, 1);
		put_text("P4 1 1 ", 1);
		put_byte(8'hFF);
		put_byte(8'h5A);                      // trailing byte after cut
		put_byte(8'h00, 0, 1);
		put_file(256, 3);                     // widest, one replay row
		put_file(9, 6);
		put_text("P4 8 2", 1);
		put_byte(8'h20, 0, 1);                // truncated on header end
		put_text("P4 3", 1);                  // abandoned by restart
		put_file(5, 4);
		drain();

		// hold the sender back for a while, then release it and drain
		put_file(12, 3);
		hold_off = 1;
		repeat (20) @(posedge clk);
		hold_off = 0;
		drain();

		// random files: mostly well formed, some truncated or noisy
		while (n_items < 255) begin
			case ($urandom_range(0, 9))
				0: put_text($sformatf("P4 %0d %0d ", $urandom_range(0, 400),
					$urandom_range(0, 3)), 1);
				1: begin
					put_text("P4", 1);
					put_byte($urandom_range(0, 255));
					put_byte($urandom_range(0, 255), 0, $urandom_range(0, 1));
				end
				2: begin
					w = $urandom_range(1, 40);
					h = $urandom_range(1, 6);
					put_file(w, h, $urandom_range(0, ((w + 7) / 8) * h - 1));
				end
				default: begin
					if ($urandom_range(0, 7) == 0) begin
						w = $urandom_range(200, 256);
						h = $urandom_range(1, 2);
					end else begin
						w = $urandom_range(1, 40);
						h = $urandom_range(1, 7);
					end
					put_file(w, h);
				end
			endcase
		end
		while (pending_bytes.size() > 60) @(posedge clk);
		quiet = 1;
		drain();
		repeat (100) @(posedge clk);
		if (n_fail == 0 && printer_bytes.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
